// ----- rtl/wide_integer_alu_with_overflow_na_assert.svh -----
// assertion helpers for the wide integer alu
`ifndef WIDE_INTEGER_ALU_WITH_OVERFLOW_NA_ASSERT_SVH
`define WIDE_INTEGER_ALU_WITH_OVERFLOW_NA_ASSERT_SVH
`ifndef SYNTH
// clocked check, off while reset is high
`define WIA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, always on
`define WIA_ASSERT_ON(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WIA_ASSERT(lbl, clk, rst, prop, msg)
`define WIA_ASSERT_ON(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/wia_pkg.sv -----
package wia_pkg;

   // widest element supported, in bytes and bits
   localparam int MAX_BYTES_DEF = 16;
   localparam int MAX_W = 128;
   // bits of an element width count (up to MAX_W)
   localparam int WCNT_W = 8;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MOD = 3'd4,
      OP_NEG = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK   = 3'd0,
      ST_OVF  = 3'd1,
      ST_DIVZ = 3'd2,
      ST_NA   = 3'd3,
      ST_UNEG = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_A_WIDTH = 2'd0,
      CSR_B_WIDTH = 2'd1,
      CSR_SIGNED  = 2'd2,
      CSR_NA      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [63:0] operand_a_low;
      logic [63:0] operand_a_high;
      logic [63:0] operand_b_low;
      logic [63:0] operand_b_high;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
      logic [2:0]  status;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0] a_code;
      logic [2:0] b_code;
      logic       sgn;
      logic       hasna;
   } cfg_type;

   // per item control traveling down the pipeline
   typedef struct packed {
      op_type              op;
      logic [WCNT_W-1:0]   w;
      logic                sgn;
      logic                hasna;
      status_type          stat;
      logic                neg_a;
      logic                neg_b;
   } ctrl_type;

   // element width in bits from a width code, capped at max_bits
   function automatic logic [WCNT_W-1:0] width_bits(logic [2:0] code, int max_bits);
      logic [2:0] c;
      int         bits;
      c = (code > 3'd4) ? 3'd4 : code;
      bits = 8 << c;
      if (bits > max_bits) bits = max_bits;
      return WCNT_W'(bits);
   endfunction

   // all ones below bit w
   function automatic logic [MAX_W-1:0] mask_of(logic [WCNT_W-1:0] w);
      return (w >= WCNT_W'(MAX_W)) ? {MAX_W{1'b1}} : ~({MAX_W{1'b1}} << w);
   endfunction

   // only bit w-1 set: signed minimum
   function automatic logic [MAX_W-1:0] min_of(logic [WCNT_W-1:0] w);
      return MAX_W'(1) << (w - WCNT_W'(1));
   endfunction

   // product width for 32 bit limbs
   function automatic int prod_bits(int dw);
      return 64 * ((dw + 31) / 32);
   endfunction

endpackage

// ----- rtl/wia_front.sv -----
module wia_front import wia_pkg::*; #(
   parameter int DW = 8 * MAX_BYTES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  req_payload_type in_req,
   input  cfg_type         cfg,
   output logic            out_valid,
   output ctrl_type        out_ctrl,
   output logic [DW-1:0]   out_a_mag,
   output logic [DW-1:0]   out_b_mag,
   output logic [DW-1:0]   out_early
);

   logic [MAX_W-1:0]  a_full, b_full, ma_full, mb_full, mw_full;
   logic [MAX_W-1:0]  mina_full, minb_full;
   logic [DW-1:0]     ma, mb, mw, a_m, b_m, napa, napb;
   logic [WCNT_W-1:0] wa, wb;
   logic              na_a, na_b;
   op_type            op;
   ctrl_type          ctrl_a_in, ctrl_a_ff;
   logic [DW-1:0]     x_in, y_in, x_ff, y_ff;
   logic              va_ff;

   // stage a: width, mask, extend, reserved operand check
   always_comb begin
      a_full = {in_req.operand_a_high, in_req.operand_a_low};
      b_full = {in_req.operand_b_high, in_req.operand_b_low};
      op = op_type'(in_req.req_type);
      wa = width_bits(cfg.a_code, DW);
      wb = width_bits(cfg.b_code, DW);
      ma_full = mask_of(wa);
      mb_full = mask_of(wb);
      mina_full = min_of(wa);
      minb_full = min_of(wb);
      ma = ma_full[DW-1:0];
      mb = mb_full[DW-1:0];
      a_m = a_full[DW-1:0] & ma;
      b_m = b_full[DW-1:0] & mb;
      napa = cfg.sgn ? mina_full[DW-1:0] : ma;
      napb = cfg.sgn ? minb_full[DW-1:0] : mb;
      na_a = cfg.hasna && (a_m == napa);
      na_b = cfg.hasna && (b_m == napb);
      ctrl_a_in = '0;
      ctrl_a_in.op = op;
      ctrl_a_in.sgn = cfg.sgn;
      ctrl_a_in.hasna = cfg.hasna;
      ctrl_a_in.stat = ST_OK;
      case (op)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            ctrl_a_in.w = (wa > wb) ? wa : wb;
            if (na_a || na_b) ctrl_a_in.stat = ST_NA;
         end
         OP_NEG: begin
            ctrl_a_in.w = wa;
            if (!cfg.sgn) ctrl_a_in.stat = ST_UNEG;
            else if (na_a) ctrl_a_in.stat = ST_NA;
         end
         default: begin
            ctrl_a_in.w = WCNT_W'(DW);
         end
      endcase
      mw_full = mask_of(ctrl_a_in.w);
      mw = mw_full[DW-1:0];
      x_in = ((cfg.sgn && |(a_m & mina_full[DW-1:0])) ? (a_m | ~ma) : a_m) & mw;
      y_in = ((cfg.sgn && |(b_m & minb_full[DW-1:0])) ? (b_m | ~mb) : b_m) & mw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_a_ff <= ctrl_a_in;
      x_ff <= x_in;
      y_ff <= y_in;
   end

   // stage b: add, subtract, negate and operand magnitudes
   logic [MAX_W-1:0] m_full, mn_full;
   logic [DW-1:0]    m, mn, nap, negx, negy, r;
   logic [DW:0]      sum, diff;
   logic             tx, ty, tr, over;
   ctrl_type         ctrl_b_in;

   always_comb begin
      m_full = mask_of(ctrl_a_ff.w);
      mn_full = min_of(ctrl_a_ff.w);
      m = m_full[DW-1:0];
      mn = mn_full[DW-1:0];
      nap = ctrl_a_ff.sgn ? mn : m;
      sum = {1'b0, x_ff} + {1'b0, y_ff};
      diff = {1'b0, x_ff} - {1'b0, y_ff};
      negx = (DW'(0) - x_ff) & m;
      negy = (DW'(0) - y_ff) & m;
      tx = |(x_ff & mn);
      ty = |(y_ff & mn);
      r = '0;
      over = 1'b0;
      case (ctrl_a_ff.op)
         OP_ADD: begin
            r = sum[DW-1:0] & m;
            tr = |(r & mn);
            over = ctrl_a_ff.sgn ? (tx == ty && tr != tx) :
                   (sum[DW] || |(sum[DW-1:0] & ~m));
         end
         OP_SUB: begin
            r = diff[DW-1:0] & m;
            tr = |(r & mn);
            over = ctrl_a_ff.sgn ? (tx != ty && tr != tx) : diff[DW];
         end
         OP_NEG: begin
            r = negx;
            tr = 1'b0;
            over = (x_ff == mn);
         end
         default: begin
            tr = 1'b0;
         end
      endcase
      ctrl_b_in = ctrl_a_ff;
      if (ctrl_a_ff.stat == ST_OK) begin
         case (ctrl_a_ff.op)
            OP_ADD, OP_SUB: begin
               if (over || (ctrl_a_ff.hasna && r == nap)) ctrl_b_in.stat = ST_OVF;
            end
            OP_NEG: begin
               if (over) ctrl_b_in.stat = ST_OVF;
            end
            default: begin
               ctrl_b_in.stat = ST_OK;
            end
         endcase
      end
      ctrl_b_in.neg_a = ctrl_a_ff.sgn && tx;
      ctrl_b_in.neg_b = ctrl_a_ff.sgn && ty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ctrl <= ctrl_b_in;
      out_a_mag <= ctrl_b_in.neg_a ? negx : x_ff;
      out_b_mag <= ctrl_b_in.neg_b ? negy : y_ff;
      out_early <= r;
   end

endmodule

// ----- rtl/wia_mul.sv -----
module wia_mul import wia_pkg::*; #(
   parameter int DW = 8 * MAX_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  ctrl_type               in_ctrl,
   input  logic [DW-1:0]          in_a_mag,
   input  logic [DW-1:0]          in_b_mag,
   input  logic [DW-1:0]          in_early,
   output logic                   out_valid,
   output ctrl_type               out_ctrl,
   output logic [DW-1:0]          out_a_mag,
   output logic [DW-1:0]          out_b_mag,
   output logic [DW-1:0]          out_early,
   output logic [prod_bits(DW)-1:0] out_prod
);

   localparam int NL = (DW + 31) / 32;
   localparam int PW = prod_bits(DW);

   typedef struct packed {
      ctrl_type      ctrl;
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      logic [DW-1:0] early;
   } carry_type;

   carry_type          car_ff [3];
   logic [2:0]         vld_ff;
   logic [32*NL-1:0]   ap, bp;
   logic [63:0]        pp_in [NL][NL];
   logic [63:0]        pp_ff [NL][NL];
   logic [PW-1:0]      row_in [NL];
   logic [PW-1:0]      row_ff [NL];
   logic [PW-1:0]      prod_in;

   // limb products, rows, total
   always_comb begin
      ap = (32*NL)'(in_a_mag);
      bp = (32*NL)'(in_b_mag);
      for (int i = 0; i < NL; i++) begin
         for (int j = 0; j < NL; j++) begin
            pp_in[i][j] = 64'(ap[32*i +: 32]) * 64'(bp[32*j +: 32]);
         end
      end
      for (int i = 0; i < NL; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NL; j++) begin
            row_in[i] = row_in[i] + (PW'(pp_ff[i][j]) << (32 * j));
         end
      end
      prod_in = '0;
      for (int i = 0; i < NL; i++) begin
         prod_in = prod_in + (row_ff[i] << (32 * i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      car_ff[0] <= '{ctrl: in_ctrl, a: in_a_mag, b: in_b_mag, early: in_early};
      car_ff[1] <= car_ff[0];
      car_ff[2] <= car_ff[1];
      pp_ff <= pp_in;
      row_ff <= row_in;
      out_prod <= prod_in;
   end

   assign out_valid = vld_ff[2];
   assign out_ctrl = car_ff[2].ctrl;
   assign out_a_mag = car_ff[2].a;
   assign out_b_mag = car_ff[2].b;
   assign out_early = car_ff[2].early;

endmodule

// ----- rtl/wia_div.sv -----
module wia_div import wia_pkg::*; #(
   parameter int DW = 8 * MAX_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  ctrl_type                 in_ctrl,
   input  logic [DW-1:0]            in_a_mag,
   input  logic [DW-1:0]            in_b_mag,
   input  logic [DW-1:0]            in_early,
   input  logic [prod_bits(DW)-1:0] in_prod,
   output logic                     out_valid,
   output ctrl_type                 out_ctrl,
   output logic [DW-1:0]            out_b_mag,
   output logic [DW-1:0]            out_early,
   output logic [prod_bits(DW)-1:0] out_prod,
   output logic [DW-1:0]            out_quot,
   output logic [DW-1:0]            out_rem
);

`include "wide_integer_alu_with_overflow_na_assert.svh"

   localparam int PW = prod_bits(DW);

   typedef struct packed {
      ctrl_type      ctrl;
      logic [DW-1:0] b;
      logic [DW-1:0] early;
      logic [PW-1:0] prod;
   } carry_type;

   carry_type     car_ff [DW];
   logic [DW-1:0] rem_ff [DW];
   logic [DW-1:0] aq_ff [DW];
   logic [DW-1:0] vld_ff;

   // one quotient bit per stage, dividend shifts out as quotient shifts in
   for (genvar k = 0; k < DW; k++) begin : g_stage
      carry_type     car_src;
      logic [DW-1:0] rem_src, aq_src, rem_in, aq_in;
      logic          vld_src, ge;
      logic [DW:0]   rem_sh;

      if (k == 0) begin : g_first
         assign car_src = '{ctrl: in_ctrl, b: in_b_mag, early: in_early, prod: in_prod};
         assign rem_src = '0;
         assign aq_src = in_a_mag;
         assign vld_src = in_valid;
      end else begin : g_next
         assign car_src = car_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign aq_src = aq_ff[k-1];
         assign vld_src = vld_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_src, aq_src[DW-1]};
         ge = rem_sh >= {1'b0, car_src.b};
         rem_in = ge ? DW'(rem_sh - {1'b0, car_src.b}) : rem_sh[DW-1:0];
         aq_in = {aq_src[DW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         car_ff[k] <= car_src;
         rem_ff[k] <= rem_in;
         aq_ff[k] <= aq_in;
      end
   end

   assign out_valid = vld_ff[DW-1];
   assign out_ctrl = car_ff[DW-1].ctrl;
   assign out_b_mag = car_ff[DW-1].b;
   assign out_early = car_ff[DW-1].early;
   assign out_prod = car_ff[DW-1].prod;
   assign out_quot = aq_ff[DW-1];
   assign out_rem = rem_ff[DW-1];

   // every item leaving the divider is one that entered it
   `WIA_ASSERT(a_div_latency, clock, reset, out_valid |-> $past(in_valid, DW), "divider lost an item")

endmodule

// ----- rtl/wia_back.sv -----
module wia_back import wia_pkg::*; #(
   parameter int DW = 8 * MAX_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  ctrl_type                 in_ctrl,
   input  logic [DW-1:0]            in_b_mag,
   input  logic [DW-1:0]            in_early,
   input  logic [prod_bits(DW)-1:0] in_prod,
   input  logic [DW-1:0]            in_quot,
   input  logic [DW-1:0]            in_rem,
   output logic                     rsp_valid,
   output rsp_payload_type          rsp_payload
);

`include "wide_integer_alu_with_overflow_na_assert.svh"

   localparam int PW = prod_bits(DW);

   // stage 1: product range, floor correction, divide by zero
   logic [MAX_W-1:0] m1_full;
   logic [DW-1:0]    m1, qv, rv, cand_in;
   logic             ovf, divz, negq, fix, neg_in, use_in;
   status_type       st_in;

   ctrl_type         ctrl1_ff;
   logic [DW-1:0]    cand_ff, early1_ff;
   logic             neg1_ff, use1_ff, v1_ff;
   status_type       st1_ff;

   always_comb begin
      m1_full = mask_of(in_ctrl.w);
      m1 = m1_full[DW-1:0];
      ovf = |(in_prod & ~(PW'(m1)));
      divz = (in_b_mag == '0);
      negq = in_ctrl.neg_a ^ in_ctrl.neg_b;
      fix = negq && (in_rem != '0);
      qv = fix ? ((in_quot + DW'(1)) & m1) : in_quot;
      rv = fix ? (in_b_mag - in_rem) : in_rem;
      cand_in = '0;
      neg_in = 1'b0;
      st_in = in_ctrl.stat;
      use_in = 1'b0;
      case (in_ctrl.op)
         OP_MUL: begin
            cand_in = in_prod[DW-1:0];
            neg_in = negq;
            if (in_ctrl.stat == ST_OK) begin
               st_in = ovf ? ST_OVF : ST_OK;
               use_in = !ovf;
            end
         end
         OP_DIV, OP_MOD: begin
            cand_in = (in_ctrl.op == OP_DIV) ? qv : rv;
            neg_in = (in_ctrl.op == OP_DIV) ? negq : in_ctrl.neg_b;
            if (in_ctrl.stat == ST_OK) begin
               st_in = divz ? ST_DIVZ : ST_OK;
               use_in = !divz;
            end
         end
         default: begin
            use_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctrl1_ff <= in_ctrl;
      cand_ff <= cand_in;
      early1_ff <= in_early;
      neg1_ff <= neg_in;
      use1_ff <= use_in;
      st1_ff <= st_in;
   end

   // stage 2: range check of the stored element, sign, reserved pattern
   logic [MAX_W-1:0] m2_full, mn2_full, res_full;
   logic [DW-1:0]    m2, mn2, outv, val;
   logic             topc, fail;
   status_type       fst;
   rsp_payload_type  rsp_in;

   always_comb begin
      m2_full = mask_of(ctrl1_ff.w);
      mn2_full = min_of(ctrl1_ff.w);
      m2 = m2_full[DW-1:0];
      mn2 = mn2_full[DW-1:0];
      topc = |(cand_ff & mn2);
      fail = !ctrl1_ff.sgn ? (ctrl1_ff.hasna && cand_ff == m2) :
             (topc && (!neg1_ff || cand_ff != mn2 || ctrl1_ff.hasna));
      outv = neg1_ff ? ((DW'(0) - cand_ff) & m2) : cand_ff;
      fst = (use1_ff && fail) ? ST_OVF : st1_ff;
      if (fst != ST_OK) val = ctrl1_ff.sgn ? mn2 : m2;
      else if (use1_ff) val = outv;
      else val = early1_ff;
      res_full = MAX_W'(val);
      rsp_in.result_low = res_full[63:0];
      rsp_in.result_high = res_full[127:64];
      rsp_in.status = fst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload <= rsp_in;
   end

   // a zero divisor found in stage 1 shows up as such on the result
   `WIA_ASSERT(a_divz_kept, clock, reset, v1_ff && st1_ff == ST_DIVZ |=> rsp_valid && rsp_payload.status == ST_DIVZ, "divide by zero status lost")

endmodule

// ----- rtl/wide_integer_alu_with_overflow_na.sv -----
// Checked integer ALU for 1 to 16 byte elements, signed or unsigned, with a
// reserved NA pattern. A request is taken on every cycle that start is high;
// busy is always low. Each request gives exactly one result, shown for one
// cycle with rsp_valid. The pipeline has two front stages, three multiplier
// stages, one divider stage per quotient bit and two result stages. Results
// come out in request order and cannot be held off.
// Write the csr registers only with no request in flight.
module wide_integer_alu_with_overflow_na import wia_pkg::*; #(
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [2:0]      csr_wdata
);

`include "wide_integer_alu_with_overflow_na_assert.svh"

   localparam int DW = 8 * MAX_BYTES;
   localparam int PW = prod_bits(DW);
   localparam int LAT = DW + 7;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{a_code: 3'd0, b_code: 3'd0, sgn: 1'b0, hasna: 1'b1};
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_A_WIDTH: cfg_ff.a_code <= csr_wdata;
            CSR_B_WIDTH: cfg_ff.b_code <= csr_wdata;
            CSR_SIGNED:  cfg_ff.sgn <= csr_wdata[0];
            CSR_NA:      cfg_ff.hasna <= csr_wdata[0];
            default:     cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign busy = 1'b0;

   logic          f_valid, m_valid, d_valid;
   ctrl_type      f_ctrl, m_ctrl, d_ctrl;
   logic [DW-1:0] f_a, f_b, f_early, m_a, m_b, m_early, d_b, d_early, d_q, d_r;
   logic [PW-1:0] m_prod, d_prod;

   // front: operand prep and add/subtract/negate
   wia_front #(.DW(DW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_payload),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_ctrl  (f_ctrl),
      .out_a_mag (f_a),
      .out_b_mag (f_b),
      .out_early (f_early)
   );

   // magnitude product
   wia_mul #(.DW(DW)) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ctrl   (f_ctrl),
      .in_a_mag  (f_a),
      .in_b_mag  (f_b),
      .in_early  (f_early),
      .out_valid (m_valid),
      .out_ctrl  (m_ctrl),
      .out_a_mag (m_a),
      .out_b_mag (m_b),
      .out_early (m_early),
      .out_prod  (m_prod)
   );

   // magnitude quotient and remainder
   wia_div #(.DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ctrl   (m_ctrl),
      .in_a_mag  (m_a),
      .in_b_mag  (m_b),
      .in_early  (m_early),
      .in_prod   (m_prod),
      .out_valid (d_valid),
      .out_ctrl  (d_ctrl),
      .out_b_mag (d_b),
      .out_early (d_early),
      .out_prod  (d_prod),
      .out_quot  (d_q),
      .out_rem   (d_r)
   );

   // result checks and output register
   wia_back #(.DW(DW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d_valid),
      .in_ctrl     (d_ctrl),
      .in_b_mag    (d_b),
      .in_early    (d_early),
      .in_prod     (d_prod),
      .in_quot     (d_q),
      .in_rem      (d_r),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // every result belongs to a request taken earlier
   `WIA_ASSERT(a_rsp_latency, clock, reset, rsp_valid |-> $past(start, LAT), "result without a request")

endmodule
